@@ rtl/dpp_pkg.sv @@
// ============================================================================
// dpp_pkg
// Shared types, constants and register codes for the depth pixel to point
// back-projection block.
// ============================================================================
`default_nettype none

package dpp_pkg;

    // Default bounds of the raster counters
    localparam int DPP_MAX_COLUMNS = 4096;
    localparam int DPP_MAX_ROWS    = 4096;

    // Configuration port geometry
    localparam int DPP_ADDR_W = 5;
    localparam int DPP_DATA_W = 32;

    // Register reset values
    localparam logic [15:0] DPP_RST_FOCAL_X   = 16'd9600;
    localparam logic [15:0] DPP_RST_FOCAL_Y   = 16'd9600;
    localparam logic [15:0] DPP_RST_CENTER_X  = 16'd5120;
    localparam logic [15:0] DPP_RST_CENTER_Y  = 16'd3840;
    localparam logic [12:0] DPP_RST_WIDTH     = 13'd640;
    localparam logic [12:0] DPP_RST_HEIGHT    = 13'd480;
    localparam logic [15:0] DPP_RST_NEAR      = 16'd350;
    localparam logic [15:0] DPP_RST_FAR       = 16'd800;

    // Coordinate saturation magnitude, 1/16 mm
    localparam logic [20:0] DPP_COORD_LIMIT = 21'd524288;

    // Quotient bits produced by the serial divider, one per cycle
    localparam int DPP_DIV_STEPS = 21;
    localparam int DPP_STEP_W    = $clog2(DPP_DIV_STEPS);

    // Register map, word index
    typedef enum logic [2:0] {
        REG_FOCAL_X      = 3'd0,
        REG_FOCAL_Y      = 3'd1,
        REG_CENTER_X     = 3'd2,
        REG_CENTER_Y     = 3'd3,
        REG_FRAME_WIDTH  = 3'd4,
        REG_FRAME_HEIGHT = 3'd5,
        REG_NEAR_LIMIT   = 3'd6,
        REG_FAR_LIMIT    = 3'd7
    } dpp_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } dpp_state_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [15:0] focal_x;
        logic [15:0] focal_y;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [15:0] near_limit;
        logic [15:0] far_limit;
    } dpp_cfg_t;

    // Strobes from the sequencer to each axis unit
    typedef struct packed {
        logic capture;
        logic mul;
        logic load;
        logic check;
        logic step;
    } dpp_axis_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/dpp_if.sv @@
// ============================================================================
// dpp_if
// Valid/ready channels for incoming pixels and outgoing points.
// ============================================================================
`default_nettype none

interface dpp_pixel_if;
    logic        valid;
    logic        ready;
    logic [15:0] depth_mm;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    modport source (output valid, depth_mm, red, green, blue, input ready);
    modport sink   (input valid, depth_mm, red, green, blue, output ready);
endinterface

interface dpp_point_if;
    logic               valid;
    logic               ready;
    logic signed [20:0] point_x;
    logic signed [20:0] point_y;
    logic        [15:0] point_z;
    logic        [7:0]  point_red;
    logic        [7:0]  point_green;
    logic        [7:0]  point_blue;

    modport source (output valid, point_x, point_y, point_z, point_red, point_green,
                    point_blue, input ready);
    modport sink   (input valid, point_x, point_y, point_z, point_red, point_green,
                    point_blue, output ready);
endinterface

`default_nettype wire

@@ rtl/depth_pixel_to_point_top.sv @@
// ============================================================================
// depth_pixel_to_point_top
// Pinhole back-projection of a raster depth stream into coloured points.
// ============================================================================
//
// Pixels arrive in raster order on the pixel channel (depth in mm plus RGB);
// column and row counters follow them and wrap at the programmed frame size
// or the counter bound if smaller. A pixel whose depth lies strictly inside
// the near/far window yields one transaction on the point channel carrying x
// and y in 1/16 mm (saturated to +/-524288), z in mm and the colour. Other
// pixels are dropped. Intrinsics, frame size and limits are written over the
// APB port; the user must do so only while idle, the block does not enforce it.
//
// Sequence: an in-range pixel is captured, multiplied, loaded into the divider
// and checked for overflow, runs the 21 bit-serial divider steps per axis and
// is handed over before the next pixel is taken. Both axes divide side by side.
// The output register decouples the sides: a finished point may wait there
// while the next pixel is worked on; a stalled receiver only holds the block
// once a second point is ready to be handed over.
// Reset clears the counters, the sequencer and the output valid, and loads
// the default register values (640x480 frame, 350..800 mm window).
//
`default_nettype none

module depth_pixel_to_point_top
    import dpp_pkg::*;
#(
    parameter int MAX_COLUMNS = DPP_MAX_COLUMNS,
    parameter int MAX_ROWS    = DPP_MAX_ROWS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [DPP_ADDR_W-1:0] paddr,
    input  wire logic [DPP_DATA_W-1:0] pwdata,
    output logic      [DPP_DATA_W-1:0] prdata,
    output logic                       pready,
    dpp_pixel_if.sink                  pixel,
    dpp_point_if.source                point
);

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam logic [13:0] MaxCols = 14'(MAX_COLUMNS);
    localparam logic [13:0] MaxRows = 14'(MAX_ROWS);
    localparam logic [DPP_STEP_W-1:0] StepLast = DPP_STEP_W'(DPP_DIV_STEPS - 1);

    dpp_cfg_t       cfg;
    dpp_axis_ctrl_t ctrl;
    dpp_state_t     state_reg;
    dpp_state_t     state_next;

    logic [DPP_STEP_W-1:0] step_reg;
    logic [DPP_STEP_W-1:0] step_next;
    logic [COL_W-1:0]      col_reg;
    logic [COL_W-1:0]      col_next;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_W-1:0]      row_next;

    logic [15:0] depth_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;

    logic               out_valid_reg;
    logic signed [20:0] out_x_reg;
    logic signed [20:0] out_y_reg;
    logic        [15:0] out_z_reg;
    logic        [7:0]  out_red_reg;
    logic        [7:0]  out_green_reg;
    logic        [7:0]  out_blue_reg;

    logic               accept;
    logic               in_range;
    logic               out_free;
    logic               out_load;
    logic [COL_W:0]     col_inc;
    logic [ROW_W:0]     row_inc;
    logic [13:0]        col_bound;
    logic [13:0]        row_bound;
    logic               col_wrap;
    logic               row_wrap;
    logic signed [20:0] coord_x;
    logic signed [20:0] coord_y;

    dpp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpp_axis u_axis_x (
        .clk    (clk),
        .ctrl   (ctrl),
        .pos16  (16'({col_reg, 4'b0000})),
        .centre (cfg.center_x),
        .depth  (pixel.depth_mm),
        .focal  (cfg.focal_x),
        .coord  (coord_x)
    );

    dpp_axis u_axis_y (
        .clk    (clk),
        .ctrl   (ctrl),
        .pos16  (16'({row_reg, 4'b0000})),
        .centre (cfg.center_y),
        .depth  (pixel.depth_mm),
        .focal  (cfg.focal_y),
        .coord  (coord_y)
    );

    assign accept   = pixel.valid & pixel.ready;
    assign in_range = (pixel.depth_mm > cfg.near_limit) && (pixel.depth_mm < cfg.far_limit);
    assign out_free = !out_valid_reg || point.ready;

    // Advance the raster position, wrapping at the smaller of frame size and bound
    always_comb
    begin
        col_inc   = {1'b0, col_reg} + 1'b1;
        row_inc   = {1'b0, row_reg} + 1'b1;
        col_bound = (14'(cfg.frame_width) < MaxCols) ? 14'(cfg.frame_width) : MaxCols;
        row_bound = (14'(cfg.frame_height) < MaxRows) ? 14'(cfg.frame_height) : MaxRows;
        col_wrap  = 14'(col_inc) >= col_bound;
        row_wrap  = 14'(row_inc) >= row_bound;
        col_next  = col_reg;
        row_next  = row_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_range)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_CHECK;
            ST_CHECK: state_next = ST_DIV;
            ST_DIV:
            begin
                if (step_reg == StepLast)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        pixel.ready  = 1'b0;
        ctrl         = '0;
        out_load     = 1'b0;
        step_next    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                pixel.ready  = 1'b1;
                ctrl.capture = pixel.valid;
            end
            ST_MUL:   ctrl.mul    = 1'b1;
            ST_LOAD:  ctrl.load   = 1'b1;
            ST_CHECK: ctrl.check  = 1'b1;
            ST_DIV:
            begin
                ctrl.step = 1'b1;
                step_next = step_reg + 1'b1;
            end
            ST_DONE:  out_load = out_free;
            default:  pixel.ready = 1'b0;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (point.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the pixel payload while the axes work, and load the output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            depth_reg <= pixel.depth_mm;
            red_reg   <= pixel.red;
            green_reg <= pixel.green;
            blue_reg  <= pixel.blue;
        end
        if (out_load)
        begin
            out_x_reg     <= coord_x;
            out_y_reg     <= coord_y;
            out_z_reg     <= depth_reg;
            out_red_reg   <= red_reg;
            out_green_reg <= green_reg;
            out_blue_reg  <= blue_reg;
        end
    end

    assign point.valid       = out_valid_reg;
    assign point.point_x     = out_x_reg;
    assign point.point_y     = out_y_reg;
    assign point.point_z     = out_z_reg;
    assign point.point_red   = out_red_reg;
    assign point.point_green = out_green_reg;
    assign point.point_blue  = out_blue_reg;

endmodule

`default_nettype wire

@@ rtl/dpp_cfg.sv @@
// ============================================================================
// dpp_cfg
// APB register file holding the camera intrinsics, frame size and depth
// window.
// ============================================================================
`default_nettype none

module dpp_cfg
    import dpp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [DPP_ADDR_W-1:0] paddr,
    input  wire logic [DPP_DATA_W-1:0] pwdata,
    output logic      [DPP_DATA_W-1:0] prdata,
    output logic                       pready,
    output dpp_cfg_t                   cfg
);

    dpp_cfg_t cfg_reg;
    dpp_cfg_t cfg_next;
    dpp_reg_t index;
    logic     wr_en;

    assign pready = 1'b1;
    assign index  = dpp_reg_t'(paddr[DPP_ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;

    // Decode the write transaction
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_FOCAL_X:      cfg_next.focal_x      = pwdata[15:0];
                REG_FOCAL_Y:      cfg_next.focal_y      = pwdata[15:0];
                REG_CENTER_X:     cfg_next.center_x     = pwdata[15:0];
                REG_CENTER_Y:     cfg_next.center_y     = pwdata[15:0];
                REG_FRAME_WIDTH:  cfg_next.frame_width  = pwdata[12:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = pwdata[12:0];
                REG_NEAR_LIMIT:   cfg_next.near_limit   = pwdata[15:0];
                REG_FAR_LIMIT:    cfg_next.far_limit    = pwdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x      <= DPP_RST_FOCAL_X;
            cfg_reg.focal_y      <= DPP_RST_FOCAL_Y;
            cfg_reg.center_x     <= DPP_RST_CENTER_X;
            cfg_reg.center_y     <= DPP_RST_CENTER_Y;
            cfg_reg.frame_width  <= DPP_RST_WIDTH;
            cfg_reg.frame_height <= DPP_RST_HEIGHT;
            cfg_reg.near_limit   <= DPP_RST_NEAR;
            cfg_reg.far_limit    <= DPP_RST_FAR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (index)
            REG_FOCAL_X:      prdata = {16'd0, cfg_reg.focal_x};
            REG_FOCAL_Y:      prdata = {16'd0, cfg_reg.focal_y};
            REG_CENTER_X:     prdata = {16'd0, cfg_reg.center_x};
            REG_CENTER_Y:     prdata = {16'd0, cfg_reg.center_y};
            REG_FRAME_WIDTH:  prdata = {19'd0, cfg_reg.frame_width};
            REG_FRAME_HEIGHT: prdata = {19'd0, cfg_reg.frame_height};
            REG_NEAR_LIMIT:   prdata = {16'd0, cfg_reg.near_limit};
            REG_FAR_LIMIT:    prdata = {16'd0, cfg_reg.far_limit};
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/dpp_axis.sv @@
// ============================================================================
// dpp_axis
// One axis of the back-projection: offset from the principal point, one
// registered multiply, then a bit-serial restoring divider that shifts one
// quotient bit per cycle, with rounding and saturation on the way out.
// ============================================================================
`default_nettype none

module dpp_axis
    import dpp_pkg::*;
(
    input  wire logic               clk,
    input  dpp_axis_ctrl_t          ctrl,
    input  wire logic        [15:0] pos16,
    input  wire logic        [15:0] centre,
    input  wire logic        [15:0] depth,
    input  wire logic        [15:0] focal,
    output logic signed      [20:0] coord
);

    logic        neg_reg;
    logic [15:0] mag_reg;
    logic [15:0] depth_reg;
    logic [31:0] prod_reg;
    logic        zero_reg;
    logic        ovf_reg;
    logic [16:0] rem_reg;
    logic [20:0] quo_reg;

    logic [16:0] diff;
    logic [16:0] neg_diff;
    logic [15:0] mag_next;
    logic [37:0] dividend;
    logic [16:0] divisor;
    logic [17:0] trial;
    logic [17:0] trial_sub;
    logic        take;
    logic [20:0] sat;

    // Signed offset of the pixel from the principal point, as sign and magnitude
    assign diff     = {1'b0, pos16} - {1'b0, centre};
    assign neg_diff = 17'd0 - diff;
    assign mag_next = diff[16] ? neg_diff[15:0] : diff[15:0];

    // Round to nearest: (2*16*mag*depth + f) / (2*f)
    assign dividend = {1'b0, prod_reg, 5'b00000} + {22'd0, focal};
    assign divisor  = {focal, 1'b0};

    // One restoring step: bring down the next dividend bit and try a subtract
    assign trial     = {rem_reg, quo_reg[20]};
    assign trial_sub = trial - {1'b0, divisor};
    assign take      = trial >= {1'b0, divisor};

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            neg_reg   <= diff[16];
            mag_reg   <= mag_next;
            depth_reg <= depth;
        end
        if (ctrl.mul)
        begin
            prod_reg <= mag_reg * depth_reg;
        end
        if (ctrl.check)
        begin
            // Quotient would need more than the shifted bits
            ovf_reg <= rem_reg >= divisor;
        end
        if (ctrl.load)
        begin
            rem_reg  <= dividend[37:21];
            quo_reg  <= dividend[20:0];
            zero_reg <= prod_reg == 32'd0;
        end
        else if (ctrl.step)
        begin
            rem_reg <= take ? trial_sub[16:0] : trial[16:0];
            quo_reg <= {quo_reg[19:0], take};
        end
    end

    // Saturate the magnitude and restore the sign
    always_comb
    begin
        if (zero_reg)
        begin
            sat = '0;
        end
        else if (ovf_reg || (quo_reg > DPP_COORD_LIMIT))
        begin
            sat = DPP_COORD_LIMIT;
        end
        else
        begin
            sat = quo_reg;
        end
        coord = neg_reg ? signed'(21'd0 - sat) : signed'(sat);
    end

endmodule

`default_nettype wire

@@ rtl/dpp_checker.sv @@
// ============================================================================
// dpp_checker
// Port-level assertions for the depth pixel to point block, bound to the top.
// ============================================================================
`default_nettype none

module dpp_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               pixel_valid,
    input wire logic               pixel_ready,
    input wire logic               point_valid,
    input wire logic               point_ready,
    input wire logic signed [20:0] point_x,
    input wire logic signed [20:0] point_y,
    input wire logic        [15:0] point_z
);

    // A waiting point holds its payload until taken
    a_point_hold: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_ready |=>
            point_valid && $stable(point_x) && $stable(point_y) && $stable(point_z))
        else $error("point payload changed while stalled");

    // Coordinates stay inside the saturation window
    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid |->
            (point_x >= -21'sd524288) && (point_x <= 21'sd524288) &&
            (point_y >= -21'sd524288) && (point_y <= 21'sd524288))
        else $error("point coordinate outside saturation range");

    // The block only goes busy after taking a pixel
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(pixel_ready) |-> $past(pixel_valid && pixel_ready))
        else $error("pixel ready dropped without a transaction");

    // A new point is never raised straight after a pixel transaction
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(point_valid) |->
            !$past(pixel_valid && pixel_ready, 1) && !$past(pixel_valid && pixel_ready, 2))
        else $error("point produced faster than the divider allows");

endmodule

bind depth_pixel_to_point_top dpp_checker u_dpp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel.valid),
    .pixel_ready (pixel.ready),
    .point_valid (point.valid),
    .point_ready (point.ready),
    .point_x     (point.point_x),
    .point_y     (point.point_y),
    .point_z     (point.point_z)
);

`default_nettype wire

@@ sim/tb_depth_pixel_to_point_top.sv @@
// ============================================================================
// tb_depth_pixel_to_point_top
// Self-checking bench for the depth pixel to point back-projection block.
// Pixels are pushed through the valid/ready pixel channel with random gaps
// while the point channel stalls at random. Each accepted pixel is run
// through a local projection model holding its own copy of the registers
// and raster counters; every point transaction is compared field by field
// with the oldest predicted point. Directed checks cover the depth window
// edges, zero and extreme focal lengths, rounding ties, crossed limits,
// frame shrink and column and row counter wrap, followed by random
// register settings with mostly in-window pixel streams.
// ============================================================================
`timescale 1ns / 100ps

module tb_depth_pixel_to_point_top;
    import dpp_pkg::*;

    localparam int SETTLE_CYCLES  = 30;
    localparam int QUIET_LIMIT    = 2000;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_PIXELS   = 70;

    typedef struct packed {
        logic [20:0] x;
        logic [20:0] y;
        logic [15:0] z;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } point_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [DPP_ADDR_W-1:0] paddr;
    logic [DPP_DATA_W-1:0] pwdata;
    logic [DPP_DATA_W-1:0] prdata;
    logic                  pready;

    dpp_pixel_if pix_bus ();
    dpp_point_if pt_bus ();

    // Local copy of the registers and raster position
    dpp_cfg_t    model_cfg;
    logic [11:0] col_pos;
    logic [11:0] row_pos;

    point_t      expected_points[$];
    int          mismatches;
    int          points_seen;
    int          src_idle_pct;
    int          sink_idle_pct;

    depth_pixel_to_point_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pixel   (pix_bus),
        .point   (pt_bus)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Projection model
    // ------------------------------------------------------------------------

    // One axis in 1/16 mm, rounded half away from zero and saturated
    function automatic logic [20:0] back_project(logic [11:0] pos, logic [15:0] centre,
                                                 logic [15:0] depth, logic [15:0] focal);
        longint            diff;
        longint unsigned   mag;
        longint unsigned   num;
        longint unsigned   quo;
        logic [20:0]       q21;
        diff = longint'(pos) * 16 - longint'(centre);
        mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
        num  = mag * 64'd16 * longint'(depth);
        if (focal == 16'd0)
            quo = (num != 64'd0) ? longint'(DPP_COORD_LIMIT) : 64'd0;
        else
            quo = (64'd2 * num + longint'(focal)) / (64'd2 * longint'(focal));
        if (quo > longint'(DPP_COORD_LIMIT))
            quo = longint'(DPP_COORD_LIMIT);
        q21 = quo[20:0];
        return (diff < 0) ? -q21 : q21;
    endfunction

    // Predict the point for an accepted pixel, then advance the raster
    task automatic predict_pixel(logic [15:0] depth, logic [7:0] r, logic [7:0] g,
                                 logic [7:0] b);
        point_t      pt;
        int unsigned nxt;
        int unsigned col_bound;
        int unsigned row_bound;
        if (depth > model_cfg.near_limit && depth < model_cfg.far_limit)
        begin
            pt.x     = back_project(col_pos, model_cfg.center_x, depth, model_cfg.focal_x);
            pt.y     = back_project(row_pos, model_cfg.center_y, depth, model_cfg.focal_y);
            pt.z     = depth;
            pt.red   = r;
            pt.green = g;
            pt.blue  = b;
            expected_points.insert(expected_points.size(), pt);
        end
        col_bound = (model_cfg.frame_width < DPP_MAX_COLUMNS) ?
                    model_cfg.frame_width : DPP_MAX_COLUMNS;
        row_bound = (model_cfg.frame_height < DPP_MAX_ROWS) ?
                    model_cfg.frame_height : DPP_MAX_ROWS;
        nxt = col_pos + 1;
        if (nxt >= col_bound)
        begin
            col_pos = 12'd0;
            nxt = row_pos + 1;
            row_pos = (nxt >= row_bound) ? 12'd0 : 12'(nxt);
        end
        else
        begin
            col_pos = 12'(nxt);
        end
    endtask

    // ------------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------------

    // Mostly short gaps, a few long ones
    function automatic int idle_len(int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // APB write: setup then access, register taken on the access edge
    task automatic write_reg(dpp_reg_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DPP_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FOCAL_X:      model_cfg.focal_x      = value[15:0];
            REG_FOCAL_Y:      model_cfg.focal_y      = value[15:0];
            REG_CENTER_X:     model_cfg.center_x     = value[15:0];
            REG_CENTER_Y:     model_cfg.center_y     = value[15:0];
            REG_FRAME_WIDTH:  model_cfg.frame_width  = value[12:0];
            REG_FRAME_HEIGHT: model_cfg.frame_height = value[12:0];
            REG_NEAR_LIMIT:   model_cfg.near_limit   = value[15:0];
            REG_FAR_LIMIT:    model_cfg.far_limit    = value[15:0];
            default: ;
        endcase
    endtask

    // Send one pixel; returns on the edge at which it is accepted
    task automatic send_pixel(logic [15:0] depth, logic [7:0] r, logic [7:0] g,
                              logic [7:0] b);
        int gap;
        gap = idle_len(src_idle_pct);
        if (gap > 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_bus.valid    <= 1'b1;
        pix_bus.depth_mm <= depth;
        pix_bus.red      <= r;
        pix_bus.green    <= g;
        pix_bus.blue     <= b;
        do
            @(posedge clk);
        while (!pix_bus.ready);
        predict_pixel(depth, r, g, b);
    endtask

    task automatic send_random_colour(logic [15:0] depth);
        send_pixel(depth, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    endtask

    // Hold the sender until every predicted point has been taken
    task automatic wait_for_points();
        pix_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_points.size() != 0);
    endtask

    // Drain and let the block go idle before touching registers
    task automatic settle();
        wait_for_points();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure on the point channel
    // ------------------------------------------------------------------------
    initial
    begin : sink_stalls
        int hold;
        hold = 0;
        pt_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                pt_bus.ready <= 1'b0;
            end
            else
            begin
                pt_bus.ready <= 1'b1;
                hold = idle_len(sink_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Point checker
    // ------------------------------------------------------------------------
    task automatic check_field(string name, int idx, logic [20:0] got, logic [20:0] want);
        if (got !== want)
            report_mismatch($sformatf("point %0d %s got 0x%0h want 0x%0h",
                                      idx, name, got, want));
    endtask

    always @(posedge clk)
    begin : point_check
        point_t want;
        if (rst_n && pt_bus.valid && pt_bus.ready)
        begin
            if (expected_points.size() == 0)
            begin
                report_mismatch($sformatf("point %0d with none expected", points_seen));
            end
            else
            begin
                want = expected_points.pop_front();
                check_field("x", points_seen, pt_bus.point_x, want.x);
                check_field("y", points_seen, pt_bus.point_y, want.y);
                check_field("z", points_seen, 21'(pt_bus.point_z), 21'(want.z));
                check_field("red", points_seen, 21'(pt_bus.point_red), 21'(want.red));
                check_field("green", points_seen, 21'(pt_bus.point_green), 21'(want.green));
                check_field("blue", points_seen, 21'(pt_bus.point_blue), 21'(want.blue));
            end
            points_seen++;
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if ((pix_bus.valid && pix_bus.ready) || (pt_bus.valid && pt_bus.ready) || psel)
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: depths on and just inside the window edges, plus zero and full scale
    task automatic test_default_window();
        send_pixel(16'd350,   8'd0,   8'd0,   8'd0);
        send_pixel(16'd351,   8'd255, 8'd255, 8'd255);
        send_pixel(16'd799,   8'd0,   8'd0,   8'd0);
        send_pixel(16'd800,   8'd255, 8'd255, 8'd255);
        send_pixel(16'd0,     8'd0,   8'd0,   8'd0);
        send_pixel(16'd65535, 8'd255, 8'd255, 8'd255);
    endtask

    // Zero and extreme focal lengths, zero frame size, rounding ties
    task automatic test_projection_extremes();
        settle();
        write_reg(REG_NEAR_LIMIT, 32'd0);
        write_reg(REG_FAR_LIMIT, 32'd65535);
        write_reg(REG_FRAME_WIDTH, 32'd0);
        write_reg(REG_FRAME_HEIGHT, 32'd0);
        write_reg(REG_FOCAL_X, 32'd0);
        write_reg(REG_FOCAL_Y, 32'd65535);
        write_reg(REG_CENTER_X, 32'd65535);
        write_reg(REG_CENTER_Y, 32'd0);
        send_pixel(16'd65534, 8'd255, 8'd0, 8'd255);
        send_pixel(16'd1, 8'd0, 8'd255, 8'd0);
        // zero focal length with zero offset gives zero
        settle();
        write_reg(REG_CENTER_X, 32'd0);
        write_reg(REG_FOCAL_Y, 32'd0);
        send_pixel(16'd2, 8'd1, 8'd2, 8'd3);
        // half-pixel ties round away from zero
        settle();
        write_reg(REG_FOCAL_X, 32'd32);
        write_reg(REG_CENTER_X, 32'd1);
        write_reg(REG_FOCAL_Y, 32'd1);
        write_reg(REG_CENTER_Y, 32'd65535);
        send_pixel(16'd1, 8'd128, 8'd64, 8'd32);
        send_pixel(16'd3, 8'd127, 8'd191, 8'd223);
    endtask

    // Near limit not below far limit: nothing passes
    task automatic test_crossed_limits();
        settle();
        write_reg(REG_NEAR_LIMIT, 32'd900);
        write_reg(REG_FAR_LIMIT, 32'd900);
        send_pixel(16'd900, 8'd10, 8'd20, 8'd30);
        send_pixel(16'd899, 8'd10, 8'd20, 8'd30);
        send_pixel(16'd901, 8'd10, 8'd20, 8'd30);
        settle();
        write_reg(REG_NEAR_LIMIT, 32'd1000);
        write_reg(REG_FAR_LIMIT, 32'd10);
        send_pixel(16'd500, 8'd10, 8'd20, 8'd30);
    endtask

    // Shrink the frame while the column counter sits beyond the new width
    task automatic test_frame_shrink();
        settle();
        write_reg(REG_NEAR_LIMIT, 32'd0);
        write_reg(REG_FAR_LIMIT, 32'd65535);
        write_reg(REG_FOCAL_X, 32'(DPP_RST_FOCAL_X));
        write_reg(REG_FOCAL_Y, 32'(DPP_RST_FOCAL_Y));
        write_reg(REG_CENTER_X, 32'(DPP_RST_CENTER_X));
        write_reg(REG_CENTER_Y, 32'(DPP_RST_CENTER_Y));
        write_reg(REG_FRAME_WIDTH, 32'd8);
        write_reg(REG_FRAME_HEIGHT, 32'd3);
        repeat (6) send_random_colour(16'($urandom_range(1, 65534)));
        settle();
        write_reg(REG_FRAME_WIDTH, 32'd2);
        write_reg(REG_FRAME_HEIGHT, 32'd1);
        repeat (3) send_random_colour(16'($urandom_range(1, 65534)));
    endtask

    // Walk the column and row counters up to their wrap
    task automatic test_raster_wrap();
        src_idle_pct = 0;
        settle();
        write_reg(REG_NEAR_LIMIT, 32'd0);
        write_reg(REG_FAR_LIMIT, 32'd0);
        write_reg(REG_FRAME_WIDTH, 32'd40);
        write_reg(REG_FRAME_HEIGHT, 32'd2);
        while (col_pos < 12'd38)
            send_random_colour(16'($urandom_range(0, 65535)));
        settle();
        write_reg(REG_FAR_LIMIT, 32'd65535);
        write_reg(REG_CENTER_X, 32'd0);
        write_reg(REG_FOCAL_X, 32'd1600);
        repeat (4) send_random_colour(16'($urandom_range(1, 65534)));
        // rows: one pixel per row
        settle();
        write_reg(REG_FAR_LIMIT, 32'd0);
        write_reg(REG_FRAME_WIDTH, 32'd1);
        write_reg(REG_FRAME_HEIGHT, 32'd12);
        while (row_pos < 12'd10)
            send_random_colour(16'($urandom_range(0, 65535)));
        settle();
        write_reg(REG_FAR_LIMIT, 32'd65535);
        write_reg(REG_CENTER_Y, 32'd0);
        write_reg(REG_FOCAL_Y, 32'd1600);
        repeat (6) send_random_colour(16'($urandom_range(1, 65534)));
    endtask

    function automatic logic [31:0] pick_focal();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 17)
            return $urandom_range(1600, 65535);
        if (sel < 19)
            return $urandom_range(1, 1599);
        return 32'd0;
    endfunction

    function automatic logic [31:0] pick_frame_size();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return $urandom_range(1, 24);
        if (sel < 8)
            return $urandom_range(25, 640);
        if (sel == 8)
            return 32'd0;
        return $urandom_range(4096, 8191);
    endfunction

    // Centre either anywhere or inside the programmed frame
    function automatic logic [31:0] pick_centre(logic [12:0] size);
        int unsigned span;
        span = 16 * ((size < DPP_MAX_COLUMNS) ? size : DPP_MAX_COLUMNS);
        if (span > 65535)
            span = 65535;
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 65535);
        return $urandom_range(0, span);
    endfunction

    // Random register settings, mostly in-window pixel streams
    task automatic test_random_phases();
        int unsigned near_mm;
        int unsigned far_mm;
        int unsigned sel;
        logic [15:0] depth;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            settle();
            // first phase runs flat out on both sides
            src_idle_pct  = (phase == 0) ? 0 : 10 * $urandom_range(1, 6);
            sink_idle_pct = (phase == 0) ? 0 : 10 * $urandom_range(1, 6);
            sel = $urandom_range(0, 9);
            if (sel < 8)
            begin
                near_mm = $urandom_range(0, 60000);
                far_mm  = near_mm + $urandom_range(2, 5000);
                if (far_mm > 65535)
                    far_mm = 65535;
            end
            else if (sel == 8)
            begin
                near_mm = 0;
                far_mm  = 65535;
            end
            else
            begin
                far_mm  = $urandom_range(0, 65535);
                near_mm = $urandom_range(far_mm, 65535);
            end
            write_reg(REG_FOCAL_X, pick_focal());
            write_reg(REG_FOCAL_Y, pick_focal());
            write_reg(REG_FRAME_WIDTH, pick_frame_size());
            write_reg(REG_FRAME_HEIGHT, pick_frame_size());
            write_reg(REG_CENTER_X, pick_centre(model_cfg.frame_width));
            write_reg(REG_CENTER_Y, pick_centre(model_cfg.frame_height));
            write_reg(REG_NEAR_LIMIT, near_mm);
            write_reg(REG_FAR_LIMIT, far_mm);
            for (int n = 0; n < PHASE_PIXELS; n++)
            begin
                if ($urandom_range(0, 99) < 3)
                    wait_for_points();
                sel = $urandom_range(0, 99);
                if (sel < 75 && far_mm > near_mm + 1)
                    depth = 16'($urandom_range(near_mm + 1, far_mm - 1));
                else if (sel < 85)
                    depth = 16'(($urandom_range(0, 1) == 0) ? near_mm : far_mm);
                else
                    depth = 16'($urandom_range(0, 65535));
                send_random_colour(depth);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        pix_bus.valid    <= 1'b0;
        pix_bus.depth_mm <= '0;
        pix_bus.red      <= '0;
        pix_bus.green    <= '0;
        pix_bus.blue     <= '0;
        mismatches    = 0;
        points_seen   = 0;
        src_idle_pct  = 30;
        sink_idle_pct = 30;
        col_pos       = 12'd0;
        row_pos       = 12'd0;
        model_cfg.focal_x      = DPP_RST_FOCAL_X;
        model_cfg.focal_y      = DPP_RST_FOCAL_Y;
        model_cfg.center_x     = DPP_RST_CENTER_X;
        model_cfg.center_y     = DPP_RST_CENTER_Y;
        model_cfg.frame_width  = DPP_RST_WIDTH;
        model_cfg.frame_height = DPP_RST_HEIGHT;
        model_cfg.near_limit   = DPP_RST_NEAR;
        model_cfg.far_limit    = DPP_RST_FAR;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_window();
        test_projection_extremes();
        test_crossed_limits();
        test_frame_shrink();
        test_raster_wrap();
        test_random_phases();

        settle();
        if (expected_points.size() != 0)
            report_mismatch($sformatf("%0d points never arrived", expected_points.size()));
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/dpp_pkg.sv
rtl/dpp_if.sv
rtl/dpp_cfg.sv
rtl/dpp_axis.sv
rtl/depth_pixel_to_point_top.sv
rtl/dpp_checker.sv
sim/tb_depth_pixel_to_point_top.sv
